FILE: hw/rtl/sffc_pkg.sv
// ----------------------------------------------------------------------------
// sffc_pkg
// Shared types, constants and constant tables for the stereo compressor.
// ----------------------------------------------------------------------------
package sffc_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int RAMP_SAMPLES = 960;

	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 32;
	localparam int RAMP_CNT_BITS  = $clog2(RAMP_SAMPLES + 1);

	// Register map.
	localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD   = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_SLOPE = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK      = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE     = 4'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LIM_ATTACK  = 4'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LIMITER     = 4'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAKEUP      = 4'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIX         = 4'd7;

	// Reset values.
	localparam logic signed [14:0] RST_THRESHOLD   = -15'sd4608;
	localparam logic [15:0]        RST_RATIO_SLOPE = 16'd49152;
	localparam logic [15:0]        RST_ATTACK      = 16'd65366;
	localparam logic [15:0]        RST_RELEASE     = 16'd65524;
	localparam logic [15:0]        RST_LIM_ATTACK  = 16'd62861;
	localparam logic [19:0]        RST_MAKEUP      = 20'd130762;
	localparam logic [16:0]        MIX_ONE         = 17'd65536;

	// Arithmetic constants.
	localparam logic signed [15:0] DB_FLOOR      = -16'sd25600;
	localparam logic [23:0]        DB_FLOOR_MAG  = 24'd25600;
	localparam logic [18:0]        DB_PER_OCT    = 19'd394566;
	localparam logic [21:0]        OCT_PER_DB    = 22'd2786635;
	localparam logic [15:0]        LIMITER_SLOPE = 16'd64881;

	// Truncating division by the ramp length through a reciprocal.
	localparam int          RAMP_RECIP_SHIFT = 32;
	localparam logic [32:0] RAMP_RECIP =
		33'(((64'd1 << RAMP_RECIP_SHIFT) + 64'(RAMP_SAMPLES) - 64'd1) / 64'(RAMP_SAMPLES));

	// Micro-operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_LOG_MUL, OP_LOG_WB,
		OP_DB_MUL, OP_DB_WB,
		OP_ENV_MUL, OP_ENV_WB,
		OP_GR_MUL, OP_GR_WB,
		OP_EXP_MUL, OP_EXP_WB,
		OP_GAIN_MUL, OP_GAIN_WB, OP_GAIN_FIN,
		OP_TOT_MUL, OP_TOT_WB,
		OP_MIX_MUL, OP_MIX_WB,
		OP_OUTL_MUL, OP_OUTL_WB,
		OP_OUTR_MUL, OP_OUTR_WB
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] iter;
	} sffc_cmd_t;

	typedef struct packed {
		logic gain_bit;
	} sffc_status_t;

	typedef logic [15:0][29:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > x) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// Entry k is 2^(-2^-(k+1)) in Q0.30, built by repeated square roots.
	function automatic root_tab_t make_roots();
		root_tab_t   t;
		logic [63:0] w;
		w = 64'd1 << 29;
		for (int k = 0; k < 16; k++) begin
			w = isqrt64(w << 30);
			t[k] = w[29:0];
		end
		return t;
	endfunction

	localparam root_tab_t GAIN_ROOTS = make_roots();

	// Round half up by 2^16, then clamp to the sample range.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [67:0] p);
		logic signed [67:0] r;
		r = (p + 68'sd32768) >>> 16;
		if (r > 68'sd0 + ((68'sd1 <<< (SAMPLE_BITS - 1)) - 68'sd1))
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		else if (r < -(68'sd1 <<< (SAMPLE_BITS - 1)))
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			return r[SAMPLE_BITS-1:0];
	endfunction

endpackage

FILE: hw/rtl/sffc_ctrl.sv
// ----------------------------------------------------------------------------
// sffc_ctrl
// Sequencer that steps the shared multiplier through one sample pair.
// ----------------------------------------------------------------------------
module sffc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  sffc_pkg::sffc_status_t status,
	output sffc_pkg::sffc_cmd_t   cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOG_MUL, S_LOG_WB,
		S_DB_MUL, S_DB_WB,
		S_ENV_MUL, S_ENV_WB,
		S_GR_MUL, S_GR_WB,
		S_EXP_MUL, S_EXP_WB,
		S_GAIN_MUL, S_GAIN_WB, S_GAIN_FIN,
		S_TOT_MUL, S_TOT_WB,
		S_MIX_MUL, S_MIX_WB,
		S_OUTL_MUL, S_OUTL_WB,
		S_OUTR_MUL, S_OUTR_WB
	} state_t;

	state_t     state_q;
	logic [3:0] iter_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.iter = iter_q;
		case (state_q)
			S_IDLE:     cmd.op = in_valid ? sffc_pkg::OP_LOAD : sffc_pkg::OP_NONE;
			S_LOG_MUL:  cmd.op = sffc_pkg::OP_LOG_MUL;
			S_LOG_WB:   cmd.op = sffc_pkg::OP_LOG_WB;
			S_DB_MUL:   cmd.op = sffc_pkg::OP_DB_MUL;
			S_DB_WB:    cmd.op = sffc_pkg::OP_DB_WB;
			S_ENV_MUL:  cmd.op = sffc_pkg::OP_ENV_MUL;
			S_ENV_WB:   cmd.op = sffc_pkg::OP_ENV_WB;
			S_GR_MUL:   cmd.op = sffc_pkg::OP_GR_MUL;
			S_GR_WB:    cmd.op = sffc_pkg::OP_GR_WB;
			S_EXP_MUL:  cmd.op = sffc_pkg::OP_EXP_MUL;
			S_EXP_WB:   cmd.op = sffc_pkg::OP_EXP_WB;
			S_GAIN_MUL: cmd.op = status.gain_bit ? sffc_pkg::OP_GAIN_MUL : sffc_pkg::OP_NONE;
			S_GAIN_WB:  cmd.op = sffc_pkg::OP_GAIN_WB;
			S_GAIN_FIN: cmd.op = sffc_pkg::OP_GAIN_FIN;
			S_TOT_MUL:  cmd.op = sffc_pkg::OP_TOT_MUL;
			S_TOT_WB:   cmd.op = sffc_pkg::OP_TOT_WB;
			S_MIX_MUL:  cmd.op = sffc_pkg::OP_MIX_MUL;
			S_MIX_WB:   cmd.op = sffc_pkg::OP_MIX_WB;
			S_OUTL_MUL: cmd.op = sffc_pkg::OP_OUTL_MUL;
			S_OUTL_WB:  cmd.op = sffc_pkg::OP_OUTL_WB;
			S_OUTR_MUL: cmd.op = sffc_pkg::OP_OUTR_MUL;
			S_OUTR_WB:  cmd.op = out_free ? sffc_pkg::OP_OUTR_WB : sffc_pkg::OP_NONE;
			default:    cmd.op = sffc_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces a taken one in the same cycle.
			if (state_q == S_OUTR_WB && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					iter_q <= 4'd0;
					if (in_valid) state_q <= S_LOG_MUL;
				end
				S_LOG_MUL: state_q <= S_LOG_WB;
				S_LOG_WB: begin
					if (iter_q == 4'd15) begin
						state_q <= S_DB_MUL;
					end else begin
						iter_q  <= iter_q + 4'd1;
						state_q <= S_LOG_MUL;
					end
				end
				S_DB_MUL:  state_q <= S_DB_WB;
				S_DB_WB:   state_q <= S_ENV_MUL;
				S_ENV_MUL: state_q <= S_ENV_WB;
				S_ENV_WB:  state_q <= S_GR_MUL;
				S_GR_MUL:  state_q <= S_GR_WB;
				S_GR_WB:   state_q <= S_EXP_MUL;
				S_EXP_MUL: state_q <= S_EXP_WB;
				S_EXP_WB: begin
					iter_q  <= 4'd0;
					state_q <= S_GAIN_MUL;
				end
				S_GAIN_MUL: begin
					// A clear exponent bit needs no multiply.
					if (status.gain_bit) begin
						state_q <= S_GAIN_WB;
					end else if (iter_q == 4'd15) begin
						state_q <= S_GAIN_FIN;
					end else begin
						iter_q <= iter_q + 4'd1;
					end
				end
				S_GAIN_WB: begin
					if (iter_q == 4'd15) begin
						state_q <= S_GAIN_FIN;
					end else begin
						iter_q  <= iter_q + 4'd1;
						state_q <= S_GAIN_MUL;
					end
				end
				S_GAIN_FIN: state_q <= S_TOT_MUL;
				S_TOT_MUL:  state_q <= S_TOT_WB;
				S_TOT_WB:   state_q <= S_MIX_MUL;
				S_MIX_MUL:  state_q <= S_MIX_WB;
				S_MIX_WB:   state_q <= S_OUTL_MUL;
				S_OUTL_MUL: state_q <= S_OUTL_WB;
				S_OUTL_WB:  state_q <= S_OUTR_MUL;
				S_OUTR_MUL: state_q <= S_OUTR_WB;
				S_OUTR_WB: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_load_starts_log: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_LOG_MUL && iter_q == 4'd0))
		else $error("accepted request did not start the log stage");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == sffc_pkg::OP_OUTR_WB) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUTR_WB))
		else $error("result raised outside the final stage");

	a_log_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOG_MUL) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_LOG_WB))
		else $error("log stage entered out of sequence");

endmodule

FILE: hw/rtl/sffc_dpath.sv
// ----------------------------------------------------------------------------
// sffc_dpath
// Registers, configuration, gain ramps and the shared multiplier.
// ----------------------------------------------------------------------------
module sffc_dpath (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  sffc_pkg::sffc_cmd_t                       cmd,
	output sffc_pkg::sffc_status_t                    status,
	input  logic signed [sffc_pkg::SAMPLE_BITS-1:0]   sample_left,
	input  logic signed [sffc_pkg::SAMPLE_BITS-1:0]   sample_right,
	input  logic                                      cfg_we,
	input  logic [sffc_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [sffc_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	output logic signed [sffc_pkg::SAMPLE_BITS-1:0]   out_left,
	output logic signed [sffc_pkg::SAMPLE_BITS-1:0]   out_right,
	output logic [14:0]                               reduction_db
);

	localparam int SB = sffc_pkg::SAMPLE_BITS;
	localparam int RB = sffc_pkg::RAMP_CNT_BITS;

	// Configuration.
	logic signed [14:0] thr_q;
	logic [15:0]        slope_q, att_q, rel_q, latt_q;
	logic               lim_q;
	logic [19:0]        makeup_tgt_q;
	logic [16:0]        mix_tgt_q;

	// Ramps and envelope.
	logic [20:0]        makeup_cur_q;
	logic signed [21:0] makeup_step_q;
	logic [RB-1:0]      makeup_cnt_q;
	logic [16:0]        mix_cur_q;
	logic signed [17:0] mix_step_q;
	logic [RB-1:0]      mix_cnt_q;
	logic signed [15:0] env_q;

	// Per-item working registers.
	logic signed [SB-1:0] left_q, right_q, outl_q;
	logic [32:0]          m_q;
	logic [15:0]          frac_q;
	logic [4:0]           msb_q;
	logic                 zero_q;
	logic signed [15:0]   level_q;
	logic [14:0]          gr_q;
	logic [20:0]          e_q;
	logic [30:0]          g_q;
	logic [16:0]          lin_q;
	logic [21:0]          total_q;
	logic [21:0]          blend_q;
	logic signed [67:0]   prod_q;

	// Input normalization.
	logic [SB-1:0] mag;
	logic [4:0]    msb;
	always_comb begin
		mag = sample_left[SB-1] ? SB'(-sample_left) : SB'(sample_left);
		msb = 5'd0;
		for (int k = 0; k < SB; k++) begin
			if (mag[k]) msb = 5'(k);
		end
	end

	// Ramp start: truncating divide of the distance by the ramp length.
	logic [16:0]        mix_wr;
	logic signed [22:0] rdiff;
	logic [21:0]        rabs;
	logic [54:0]        rprod;
	logic [21:0]        rq;
	logic signed [22:0] rstep;
	always_comb begin
		mix_wr = (cfg_data[16:0] > sffc_pkg::MIX_ONE) ? sffc_pkg::MIX_ONE : cfg_data[16:0];
		if (cfg_index == sffc_pkg::REG_MIX)
			rdiff = $signed({6'd0, mix_wr}) - $signed({6'd0, mix_cur_q});
		else
			rdiff = $signed({3'd0, cfg_data[19:0]}) - $signed({2'd0, makeup_cur_q});
		rabs  = rdiff[22] ? 22'(-rdiff) : 22'(rdiff);
		rprod = 55'(rabs) * 55'(sffc_pkg::RAMP_RECIP);
		rq    = rprod[sffc_pkg::RAMP_RECIP_SHIFT +: 22];
		rstep = rdiff[22] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
	end

	// Multiplier operand selection.
	logic signed [33:0] mul_a, mul_b;
	logic               mul_en;
	logic signed [16:0] env_diff, thr_diff;
	logic [20:0]        neg_log;
	logic [15:0]        coeff;
	always_comb begin
		env_diff = env_q - level_q;
		thr_diff = env_q - thr_q;
		neg_log  = {5'(SB - 1) - msb_q, 16'd0} - {5'd0, frac_q};
		if (level_q > env_q)
			coeff = lim_q ? latt_q : att_q;
		else
			coeff = rel_q;
		mul_en = 1'b1;
		mul_a  = 34'sd0;
		mul_b  = 34'sd0;
		case (cmd.op)
			sffc_pkg::OP_LOG_MUL: begin
				mul_a = $signed({1'b0, m_q});
				mul_b = $signed({1'b0, m_q});
			end
			sffc_pkg::OP_DB_MUL: begin
				mul_a = $signed(34'(neg_log));
				mul_b = $signed(34'(sffc_pkg::DB_PER_OCT));
			end
			sffc_pkg::OP_ENV_MUL: begin
				mul_a = 34'(env_diff);
				mul_b = $signed(34'(coeff));
			end
			sffc_pkg::OP_GR_MUL: begin
				mul_a = (env_q > thr_q) ? 34'(thr_diff) : 34'sd0;
				mul_b = $signed(34'(lim_q ? sffc_pkg::LIMITER_SLOPE : slope_q));
			end
			sffc_pkg::OP_EXP_MUL: begin
				mul_a = $signed(34'(gr_q));
				mul_b = $signed(34'(sffc_pkg::OCT_PER_DB));
			end
			sffc_pkg::OP_GAIN_MUL: begin
				mul_a = $signed(34'(g_q));
				mul_b = $signed(34'(sffc_pkg::GAIN_ROOTS[cmd.iter]));
			end
			sffc_pkg::OP_TOT_MUL: begin
				mul_a = $signed(34'(makeup_cur_q));
				mul_b = $signed(34'(lin_q));
			end
			sffc_pkg::OP_MIX_MUL: begin
				mul_a = $signed(34'(total_q));
				mul_b = $signed(34'(mix_cur_q));
			end
			sffc_pkg::OP_OUTL_MUL: begin
				mul_a = 34'(left_q);
				mul_b = $signed(34'(blend_q));
			end
			sffc_pkg::OP_OUTR_MUL: begin
				mul_a = 34'(right_q);
				mul_b = $signed(34'(blend_q));
			end
			default: mul_en = 1'b0;
		endcase
	end

	// Write-back arithmetic.
	logic [32:0]        m_sq;
	logic [47:0]        db_rnd;
	logic [23:0]        db_mag;
	logic signed [67:0] rs16;
	logic [67:0]        ru16, ru30;
	logic [63:0]        gsum;
	logic [4:0]         oct;
	logic [67:0]        bsum;
	always_comb begin
		m_sq   = prod_q[63:31];
		db_rnd = prod_q[47:0] + 48'd8388608;
		db_mag = db_rnd[47:24];
		rs16   = (prod_q + 68'sd32768) >>> 16;
		ru16   = ($unsigned(prod_q) + 68'd32768) >> 16;
		ru30   = ($unsigned(prod_q) + (68'd1 << 29)) >> 30;
		oct    = e_q[20:16];
		// The octave count cannot reach 40 here, so no separate flush to zero is needed.
		gsum   = {33'd0, g_q} + (64'd1 << (6'd13 + 6'(oct)));
		bsum   = $unsigned(prod_q) + ({51'd0, sffc_pkg::MIX_ONE - mix_cur_q} << 16)
			+ 68'd32768;
	end

	assign status.gain_bit = e_q[~cmd.iter];

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_a * mul_b;
		case (cmd.op)
			sffc_pkg::OP_LOAD: begin
				left_q  <= sample_left;
				right_q <= sample_right;
				zero_q  <= (mag == '0);
				msb_q   <= msb;
				m_q     <= 33'({32'd0, mag} << (5'd31 - msb));
				frac_q  <= 16'd0;
			end
			sffc_pkg::OP_LOG_WB: begin
				if (m_sq[32]) begin
					frac_q[~cmd.iter] <= 1'b1;
					m_q <= {1'b0, m_sq[32:1]};
				end else begin
					m_q <= m_sq;
				end
			end
			sffc_pkg::OP_DB_WB: begin
				if (zero_q || db_mag >= sffc_pkg::DB_FLOOR_MAG)
					level_q <= sffc_pkg::DB_FLOOR;
				else
					level_q <= -$signed(db_mag[15:0]);
			end
			sffc_pkg::OP_GR_WB:    gr_q <= ru16[14:0];
			sffc_pkg::OP_EXP_WB: begin
				e_q <= ru16[20:0];
				g_q <= 31'd1 << 30;
			end
			sffc_pkg::OP_GAIN_WB:  g_q <= ru30[30:0];
			sffc_pkg::OP_GAIN_FIN: lin_q <= 17'(gsum >> (6'd14 + 6'(oct)));
			sffc_pkg::OP_TOT_WB:   total_q <= ru16[21:0];
			sffc_pkg::OP_MIX_WB:   blend_q <= bsum[37:16];
			sffc_pkg::OP_OUTL_WB:  outl_q <= sffc_pkg::sat_sample(prod_q);
			sffc_pkg::OP_OUTR_WB: begin
				out_left     <= outl_q;
				out_right    <= sffc_pkg::sat_sample(prod_q);
				reduction_db <= gr_q;
			end
			default: ;
		endcase
	end

	// Configuration, envelope and ramp state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= sffc_pkg::RST_THRESHOLD;
			slope_q       <= sffc_pkg::RST_RATIO_SLOPE;
			att_q         <= sffc_pkg::RST_ATTACK;
			rel_q         <= sffc_pkg::RST_RELEASE;
			latt_q        <= sffc_pkg::RST_LIM_ATTACK;
			lim_q         <= 1'b0;
			makeup_tgt_q  <= sffc_pkg::RST_MAKEUP;
			mix_tgt_q     <= sffc_pkg::MIX_ONE;
			makeup_cur_q  <= 21'(sffc_pkg::RST_MAKEUP);
			makeup_step_q <= 22'sd0;
			makeup_cnt_q  <= '0;
			mix_cur_q     <= sffc_pkg::MIX_ONE;
			mix_step_q    <= 18'sd0;
			mix_cnt_q     <= '0;
			env_q         <= sffc_pkg::DB_FLOOR;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sffc_pkg::REG_THRESHOLD:   thr_q  <= $signed(cfg_data[14:0]);
					sffc_pkg::REG_RATIO_SLOPE: slope_q <= cfg_data[15:0];
					sffc_pkg::REG_ATTACK:      att_q  <= cfg_data[15:0];
					sffc_pkg::REG_RELEASE:     rel_q  <= cfg_data[15:0];
					sffc_pkg::REG_LIM_ATTACK:  latt_q <= cfg_data[15:0];
					sffc_pkg::REG_LIMITER:     lim_q  <= cfg_data[0];
					sffc_pkg::REG_MAKEUP: begin
						if (cfg_data[19:0] != makeup_tgt_q) begin
							makeup_tgt_q  <= cfg_data[19:0];
							makeup_cnt_q  <= RB'(sffc_pkg::RAMP_SAMPLES);
							makeup_step_q <= rstep[21:0];
						end
					end
					sffc_pkg::REG_MIX: begin
						if (mix_wr != mix_tgt_q) begin
							mix_tgt_q  <= mix_wr;
							mix_cnt_q  <= RB'(sffc_pkg::RAMP_SAMPLES);
							mix_step_q <= rstep[17:0];
						end
					end
					default: ;
				endcase
			end
			if (cmd.op == sffc_pkg::OP_LOAD) begin
				// Ramps advance once per sample, before the gains are used.
				if (makeup_cnt_q != '0) begin
					makeup_cnt_q <= makeup_cnt_q - RB'(1);
					if (makeup_cnt_q == RB'(1))
						makeup_cur_q <= {1'b0, makeup_tgt_q};
					else
						makeup_cur_q <= 21'($signed({2'd0, makeup_cur_q}) + makeup_step_q);
				end
				if (mix_cnt_q != '0) begin
					mix_cnt_q <= mix_cnt_q - RB'(1);
					if (mix_cnt_q == RB'(1))
						mix_cur_q <= mix_tgt_q;
					else
						mix_cur_q <= 17'($signed({1'b0, mix_cur_q}) + mix_step_q);
				end
			end
			if (cmd.op == sffc_pkg::OP_ENV_WB) env_q <= level_q + rs16[15:0];
		end
	end

endmodule

FILE: hw/rtl/stereo_feedforward_compressor.sv
// ----------------------------------------------------------------------------
// stereo_feedforward_compressor
// Stereo feed-forward compressor and limiter with a log-domain detector.
// ----------------------------------------------------------------------------
// A request on the input channel carries one stereo sample pair. The left
// sample drives the level detector; both samples get the same gain. Each
// accepted request produces exactly one result request carrying both
// processed samples and the current gain reduction in dB.
// All multiplications share one signed 34 x 34 multiplier whose product is
// registered, so every product has a multiply step and a write-back step.
// The log conversion costs 16 squarings and the dB-to-gain conversion up to
// 16 root products (one per set exponent bit). The block takes a new request
// in the cycle after the result is registered.
// The result sits in an output register: the block accepts and processes the
// next pair while it waits, and only stalls in its final write-back step if
// the previous result has still not been taken.
// Configuration writes are always ready and are meant to be issued only while
// the block is idle. After reset the settings hold their defaults, the
// envelope sits at -100 dB and the makeup and mix ramps are at rest.
// ----------------------------------------------------------------------------
module stereo_feedforward_compressor (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [sffc_pkg::SAMPLE_BITS-1:0] sample_left,
	input  logic signed [sffc_pkg::SAMPLE_BITS-1:0] sample_right,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [sffc_pkg::SAMPLE_BITS-1:0] out_left,
	output logic signed [sffc_pkg::SAMPLE_BITS-1:0] out_right,
	output logic [14:0]                             reduction_db,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [sffc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [sffc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	sffc_pkg::sffc_cmd_t    cmd;
	sffc_pkg::sffc_status_t status;

	// Register writes are applied as they arrive, so the port never pushes back.
	assign cfg_ready = 1'b1;

	sffc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sffc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_left     (out_left),
		.out_right    (out_right),
		.reduction_db (reduction_db)
	);

endmodule

FILE: tb/stereo_feedforward_compressor_test.sv
// ----------------------------------------------------------------------------
// stereo_feedforward_compressor_test
// Self-checking test of the stereo compressor: an in-bench model of the
// detector, envelope, gain curve and makeup/mix ramps predicts every result,
// and a monitor compares the processed pair and the gain reduction in order.
// ----------------------------------------------------------------------------
module stereo_feedforward_compressor_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sffc_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
	} pair_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic [14:0]                   gr;
	} processed_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;
	logic out_valid;
	logic out_ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic [14:0] reduction_db;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	stereo_feedforward_compressor u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_left(sample_left), .sample_right(sample_right),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_left(out_left), .out_right(out_right), .reduction_db(reduction_db),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the configuration and the processing state.
	longint thr, slope_r, att, rel, lim_att, lim_mode, mk_target, mix_target;
	longint env, mk_cur, mk_step, mix_cur, mix_step;
	int     mk_cnt, mix_cnt;

	pair_t      pending_pairs[$];
	processed_t expected_outputs[$];
	int         failures;
	bit         idle_free;      // no random idling while set
	bit         hold_off_req;   // asks the monitor for a long stall

	// Rounding half toward plus infinity by 2^s.
	function automatic longint round_half_up(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint root_of(longint unsigned x_in);
		longint unsigned x, r, b;
		x = x_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Level of a magnitude in dB Q8.8, floored at -100 dB.
	function automatic longint magnitude_to_db(longint unsigned a);
		int p;
		longint unsigned m, frac, neg, mag;
		p = 0;
		frac = 0;
		if (a == 0) return -25600;
		for (int k = 0; k < 40; k++) if (a[k]) p = k;
		m = (p <= 31) ? (a << (31 - p)) : (a >> (p - 31));
		for (int k = 15; k >= 0; k--) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				frac = frac | (64'd1 << k);
				m = m >> 1;
			end
		end
		neg = longint'(SAMPLE_BITS - 1 - p) * 65536 - frac;
		mag = (neg * 394566 + (64'd1 << 23)) >> 24;
		if (mag >= 25600) return -25600;
		return -longint'(mag);
	endfunction

	// Linear gain in Q1.16 for a reduction in dB Q8.8.
	function automatic longint unsigned reduction_to_gain(longint unsigned gr);
		longint unsigned e, n, f, g, w;
		e = (gr * 2786635 + 32768) >> 16;
		n = e >> 16;
		f = e & 16'hFFFF;
		g = 64'd1 << 30;
		w = 64'd1 << 29;
		for (int k = 0; k < 16; k++) begin
			w = root_of(w << 30);
			if (f[15 - k]) g = (g * w + (64'd1 << 29)) >> 30;
		end
		if (n >= 40) return 0;
		return (g + (64'd1 << (13 + n))) >> (14 + n);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(longint v);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic shadow_reset();
		thr = -4608; slope_r = 49152; att = 65366; rel = 65524; lim_att = 62861;
		lim_mode = 0; mk_target = 130762; mix_target = 65536;
		env = -25600; mk_cur = 130762; mk_step = 0; mk_cnt = 0;
		mix_cur = 65536; mix_step = 0; mix_cnt = 0;
	endtask

	task automatic shadow_write(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
		longint v;
		case (idx)
			REG_THRESHOLD: thr = longint'($signed(val[14:0]));
			REG_RATIO_SLOPE: slope_r = val[15:0];
			REG_ATTACK: att = val[15:0];
			REG_RELEASE: rel = val[15:0];
			REG_LIM_ATTACK: lim_att = val[15:0];
			REG_LIMITER: lim_mode = val[0];
			REG_MAKEUP: begin
				v = val[19:0];
				if (v != mk_target) begin
					mk_target = v;
					mk_cnt = RAMP_SAMPLES;
					mk_step = (v - mk_cur) / RAMP_SAMPLES;
				end
			end
			REG_MIX: begin
				v = val[16:0];
				if (v > 65536) v = 65536;
				if (v != mix_target) begin
					mix_target = v;
					mix_cnt = RAMP_SAMPLES;
					mix_step = (v - mix_cur) / RAMP_SAMPLES;
				end
			end
			default: ;
		endcase
	endtask

	// Advances the shadow state by one pair and returns what the block should emit.
	function automatic processed_t compress_pair(pair_t s);
		longint l, r, peak, coeff, sl, gr;
		longint unsigned lin, total, blend;
		processed_t res;
		l = s.left;
		r = s.right;
		peak = magnitude_to_db(l < 0 ? -l : l);
		if (peak > env) coeff = lim_mode ? lim_att : att;
		else coeff = rel;
		env = peak + round_half_up((env - peak) * coeff, 16);
		sl = lim_mode ? 64881 : slope_r;
		gr = 0;
		if (env > thr) gr = round_half_up((env - thr) * sl, 16);
		lin = reduction_to_gain(gr);
		if (mk_cnt > 0) begin
			mk_cnt--;
			if (mk_cnt == 0) mk_cur = mk_target;
			else mk_cur += mk_step;
		end
		if (mix_cnt > 0) begin
			mix_cnt--;
			if (mix_cnt == 0) mix_cur = mix_target;
			else mix_cur += mix_step;
		end
		total = (longint'(mk_cur) * lin + 32768) >> 16;
		blend = (65536 * longint'(65536 - mix_cur) + total * mix_cur + 32768) >> 16;
		res.left = clamp_sample(round_half_up(l * longint'(blend), 16));
		res.right = clamp_sample(round_half_up(r * longint'(blend), 16));
		res.gr = gr[14:0];
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Driver: takes pairs from the pending queue and predicts each one as it is
	// accepted, so the prediction sees the configuration in force at that time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample_left <= '0;
			sample_right <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_outputs = {expected_outputs,
					compress_pair(pair_t'({sample_left, sample_right}))};
				void'(pending_pairs.pop_front());
			end
			if (!in_valid || in_ready) begin
				// The head of the queue is always the next pair to offer.
				if (pending_pairs.size() > 0
					&& (idle_free || $urandom_range(99) >= 24)) begin
					sample_left <= pending_pairs[0].left;
					sample_right <= pending_pairs[0].right;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result with the oldest prediction.
	int hold_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_outputs.size() == 0) begin
					$error("result with no request outstanding");
					failures++;
				end else begin
					if (out_left !== expected_outputs[0].left) begin
						$error("out_left expected %0d got %0d",
							expected_outputs[0].left, out_left);
						failures++;
					end
					if (out_right !== expected_outputs[0].right) begin
						$error("out_right expected %0d got %0d",
							expected_outputs[0].right, out_right);
						failures++;
					end
					if (reduction_db !== expected_outputs[0].gr) begin
						$error("reduction_db expected %0d got %0d",
							expected_outputs[0].gr, reduction_db);
						failures++;
					end
					void'(expected_outputs.pop_front());
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else if (hold_off_req) begin
				hold_cycles <= 600;
				out_ready <= 1'b0;
			end else begin
				out_ready <= idle_free || $urandom_range(99) >= 24;
			end
		end
	end

	// One write, then a pause with cfg_valid low so consecutive writes never share an edge.
	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_write(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every prediction is matched and the pending queue is empty.
	task automatic drain();
		while (pending_pairs.size() != 0 || expected_outputs.size() != 0 || in_valid)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(5))
			0: return SAMPLE_BITS'($urandom);
			1: return $signed(SAMPLE_BITS'($urandom)) >>> $urandom_range(23);
			2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			default: return $signed(SAMPLE_BITS'($urandom)) >>> $urandom_range(12);
		endcase
	endfunction

	task automatic random_phase(int count);
		pair_t p;
		for (int i = 0; i < count; i++) begin
			p.left = random_sample();
			p.right = SAMPLE_BITS'($urandom);
			pending_pairs = {pending_pairs, p};
		end
	endtask

	task automatic random_settings();
		write_reg(REG_THRESHOLD, 32'($signed(-$urandom_range(10240))));
		write_reg(REG_RATIO_SLOPE, $urandom_range(62259));
		write_reg(REG_ATTACK, $urandom_range(65535));
		write_reg(REG_RELEASE, $urandom_range(65535));
		write_reg(REG_LIM_ATTACK, $urandom_range(65535));
		write_reg(REG_LIMITER, $urandom_range(1));
		write_reg(REG_MAKEUP, $urandom_range(1038300, 65536));
		write_reg(REG_MIX, $urandom_range(65536));
	endtask

	initial begin
		failures = 0;
		idle_free = 1'b0;
		hold_off_req = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		shadow_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at reset settings: silence, full scale both ways, the
		// most negative sample, tiny values and a loud burst that drives reduction.
		pending_pairs = {pending_pairs, pair_t'({24'sd0, 24'sd0})};
		pending_pairs = {pending_pairs, pair_t'({24'sh7FFFFF, 24'sh800000})};
		pending_pairs = {pending_pairs, pair_t'({24'sh800000, 24'sh7FFFFF})};
		pending_pairs = {pending_pairs, pair_t'({24'sd1, -24'sd1})};
		pending_pairs = {pending_pairs, pair_t'({-24'sd1, 24'sd1})};
		for (int i = 0; i < 8; i++)
			pending_pairs = {pending_pairs, pair_t'({24'sh7FFFFF, 24'sh7FFFFF})};
		pending_pairs = {pending_pairs, pair_t'({24'sd0, 24'sh555555})};
		pending_pairs = {pending_pairs, pair_t'({24'shAAAAAA, 24'sh555555})};
		drain();

		// Extremes: threshold above zero, zero coefficients, full limiter,
		// mix above one, high makeup, and writes of unchanged values.
		write_reg(REG_THRESHOLD, 32'd16383);
		write_reg(REG_ATTACK, 32'd0);
		write_reg(REG_RELEASE, 32'd0);
		write_reg(REG_MIX, 32'd131071);
		write_reg(REG_MAKEUP, 32'd130762);
		write_reg(4'd12, 32'hFFFFFFFF);
		pending_pairs = {pending_pairs, pair_t'({24'sh7FFFFF, 24'sh800000})};
		pending_pairs = {pending_pairs, pair_t'({24'sd0, 24'sd0})};
		drain();
		write_reg(REG_THRESHOLD, 32'($signed(-15'sd10240)));
		write_reg(REG_LIMITER, 32'd1);
		write_reg(REG_LIM_ATTACK, 32'd65535);
		write_reg(REG_RATIO_SLOPE, 32'd62259);
		write_reg(REG_MAKEUP, 32'd1038300);
		write_reg(REG_MIX, 32'd0);
		pending_pairs = {pending_pairs, pair_t'({24'sh7FFFFF, 24'sh7FFFFF})};
		pending_pairs = {pending_pairs, pair_t'({24'sh800000, 24'sh7FFFFF})};
		pending_pairs = {pending_pairs, pair_t'({24'sd1000, 24'sd1000})};
		drain();

		// Random phases, one ramping toward its target with no idling,
		// one with a long receiver hold-off so the block backs up.
		write_reg(REG_LIMITER, 32'd0);
		write_reg(REG_MAKEUP, 32'd65536);
		write_reg(REG_MIX, 32'd32768);
		idle_free = 1'b1;
		random_phase(120);
		drain();
		idle_free = 1'b0;
		for (int ph = 0; ph < 4; ph++) begin
			random_settings();
			if (ph == 1) begin
				// Keep asking until the monitor has started counting the stall.
				hold_off_req = 1'b1;
				wait (hold_cycles != 0);
				hold_off_req = 1'b0;
			end
			random_phase(80);
			drain();
		end

		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/sffc_pkg.sv
hw/rtl/sffc_ctrl.sv
hw/rtl/sffc_dpath.sv
hw/rtl/stereo_feedforward_compressor.sv
tb/stereo_feedforward_compressor_test.sv
